>>> src/lss_pkg.sv
package lss_pkg;

  localparam int unsigned SpinnerPositions = 8;
  localparam int unsigned SpinW            = $clog2(SpinnerPositions);

  localparam logic [31:0] HoldTimeRst = 32'd1000;
  localparam logic [31:0] SpinStepRst = 32'd100;
  localparam logic [2:0]  PageStep    = 3'd4;

  typedef enum logic [1:0] {
    ScrConnecting = 2'd0,
    ScrConnected  = 2'd1,
    ScrDirection  = 2'd2
  } screen_e;

  typedef enum logic [3:0] {
    DirStop      = 4'd0,
    DirFwd       = 4'd1,
    DirBack      = 4'd2,
    DirLeft      = 4'd3,
    DirRight     = 4'd4,
    DirFwdLeft   = 4'd5,
    DirFwdRight  = 4'd6,
    DirBackLeft  = 4'd7,
    DirBackRight = 4'd8
  } dir_e;

  typedef enum logic [1:0] {
    CfgHoldTime = 2'd0,
    CfgSpinStep = 2'd1,
    CfgDisplay  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               link_up;
    logic signed [15:0] motion_x;
    logic signed [15:0] motion_y;
  } lss_in_t;

  typedef struct packed {
    logic [1:0] screen;
    logic [3:0] direction;
    logic [2:0] spinner_phase;
    logic       redraw;
    logic [2:0] flush_page;
  } lss_out_t;

endpackage

>>> src/lss_classify.sv
module lss_classify
  import lss_pkg::*;
(
  input  logic signed [15:0] motion_x_i,
  input  logic signed [15:0] motion_y_i,
  output dir_e               dir_o
);

  logic [16:0] ax;
  logic [16:0] ay;
  logic [17:0] ax2;
  logic [17:0] ay2;
  logic        x_pos;
  logic        y_pos;

  // magnitudes kept one bit wider so -32768 does not wrap
  assign ax    = motion_x_i[15] ? 17'(-{motion_x_i[15], motion_x_i}) : 17'({1'b0, motion_x_i});
  assign ay    = motion_y_i[15] ? 17'(-{motion_y_i[15], motion_y_i}) : 17'({1'b0, motion_y_i});
  assign ax2   = {ax, 1'b0};
  assign ay2   = {ay, 1'b0};
  assign x_pos = !motion_x_i[15] && (motion_x_i != 16'sd0);
  assign y_pos = !motion_y_i[15] && (motion_y_i != 16'sd0);

  always_comb begin
    if (ax == 17'd0 && ay == 17'd0) begin
      dir_o = DirStop;
    end else if ({1'b0, ay} > ax2) begin
      dir_o = y_pos ? DirFwd : DirBack;
    end else if ({1'b0, ax} > ay2) begin
      dir_o = x_pos ? DirRight : DirLeft;
    end else if (y_pos) begin
      dir_o = x_pos ? DirFwdRight : DirFwdLeft;
    end else begin
      dir_o = x_pos ? DirBackRight : DirBackLeft;
    end
  end

endmodule

>>> src/lss_state.sv
module lss_state
  import lss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  lss_in_t     item_i,
  input  logic [31:0] hold_time_i,
  input  logic [31:0] spin_step_i,
  output lss_out_t    res_o
);

  screen_e          scr_q, scr_d;
  dir_e             dir_q, dir_d;
  logic [SpinW-1:0] phase_q, phase_d;
  logic [2:0]       page_q;
  logic             pend_q;
  logic [31:0]      since_q, since_d;
  logic [31:0]      last_q, last_d;
  logic             pend;
  dir_e             dir_new;

  lss_classify u_classify (
    .motion_x_i (item_i.motion_x),
    .motion_y_i (item_i.motion_y),
    .dir_o      (dir_new)
  );

  always_comb begin
    scr_d   = scr_q;
    dir_d   = dir_q;
    phase_d = phase_q;
    since_d = since_q;
    last_d  = last_q;
    pend    = pend_q;
    unique case (scr_q)
      ScrConnecting: begin
        if (item_i.link_up) begin
          scr_d   = ScrConnected;
          since_d = item_i.now_ms;
          pend    = 1'b1;
        end
      end
      ScrConnected: begin
        if (!item_i.link_up) begin
          scr_d = ScrConnecting;
          pend  = 1'b1;
        end else if ((item_i.now_ms - since_q) >= hold_time_i) begin
          scr_d = ScrDirection;
          pend  = 1'b1;
        end
      end
      default: begin
        if (!item_i.link_up) begin
          scr_d = ScrConnecting;
          pend  = 1'b1;
        end else if (dir_new != dir_q) begin
          dir_d = dir_new;
          pend  = 1'b1;
        end
      end
    endcase
    if (scr_d == ScrConnecting && (item_i.now_ms - last_q) >= spin_step_i) begin
      last_d  = item_i.now_ms;
      phase_d = (phase_q == SpinW'(SpinnerPositions - 1)) ? '0 : phase_q + 1'b1;
      pend    = 1'b1;
    end
    res_o.screen        = scr_d;
    res_o.direction     = dir_d;
    res_o.spinner_phase = 3'(phase_d);
    res_o.redraw        = pend;
    res_o.flush_page    = page_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q   <= ScrConnecting;
      dir_q   <= DirStop;
      phase_q <= '0;
      page_q  <= 3'd0;
      pend_q  <= 1'b1;
      since_q <= 32'd0;
      last_q  <= 32'd0;
    end else if (upd_i) begin
      scr_q   <= scr_d;
      dir_q   <= dir_d;
      phase_q <= phase_d;
      page_q  <= page_q + PageStep;
      pend_q  <= 1'b0;
      since_q <= since_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> src/link_status_screen_sequencer.sv
// Link status screen sequencer.
// Input channel: in_valid_i / in_stall_o carry one update tick per transaction
// (timestamp, link flag, motion vector). Output channel: out_valid_o /
// out_stall_i carry one screen result per tick. A transaction completes when
// valid is high and stall is low.
// Configuration: cfg_valid_i / cfg_ready_o write hold time (index 0), spinner
// step (index 1) and display present (index 2); ready is always high and
// other indexes are dropped. Write only while the block is idle.
// A tick taken into the input register moves on to the result register
// unless an output stall holds it. Throughput is one tick per cycle while
// the output is not stalled, set by the single input register to result
// register pass. Display present low: a tick is consumed, gives no result.
// Reset (rst_ni low, asynchronous) returns the connecting screen, spinner
// phase 0, redraw pending and the default register values; no clearing
// sequence is needed.
// A stalled result is held in the output register; one more tick may sit in
// the input register, after which in_stall_o rises until out_stall_i drops.
module link_status_screen_sequencer
  import lss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lss_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lss_out_t    out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        in_valid_q;
  lss_in_t     in_item_q;
  logic        out_valid_q;
  lss_out_t    out_item_q;
  logic [31:0] hold_time_q;
  logic [31:0] spin_step_q;
  logic        present_q;
  logic        out_blocked;
  logic        fire;
  logic        upd;
  logic        in_accept;
  lss_out_t    res;

  assign out_blocked = out_valid_q && out_stall_i;
  assign in_stall_o  = in_valid_q && out_blocked;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign fire        = in_valid_q && !out_blocked;
  assign upd         = fire && present_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  lss_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .item_i      (in_item_q),
    .hold_time_i (hold_time_q),
    .spin_step_i (spin_step_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (upd) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (upd) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= HoldTimeRst;
      spin_step_q <= SpinStepRst;
      present_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHoldTime: hold_time_q <= cfg_data_i;
        CfgSpinStep: spin_step_q <= cfg_data_i;
        CfgDisplay:  present_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

>>> dv/link_status_screen_sequencer_tb.sv
`timescale 1ns / 100ps

module link_status_screen_sequencer_tb;
  import lss_pkg::*;

  localparam logic [1:0]  CfgUnused  = 2'd3;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned IdlePct    = 7;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  lss_in_t     in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  lss_out_t    out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  link_status_screen_sequencer u_dut (.*);

  // screen model: configuration and state
  logic [31:0] hold_ms;
  logic [31:0] step_ms;
  logic        disp_on;
  screen_e     scr_q;
  dir_e        dir_q;
  int unsigned spin_q;
  logic [2:0]  page_q;
  logic        redraw_q;
  logic [31:0] since_q;
  logic [31:0] spun_q;

  lss_in_t     ticks_q[$];
  lss_out_t    screens_due[$];
  bit          in_taken;
  bit          calm;
  int unsigned mismatches;
  logic [31:0] clock_ms;
  logic        link_st;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("link_status_screen_sequencer_tb NOT OK");
    $finish;
  end

  function automatic dir_e sort_motion(logic signed [15:0] mx, logic signed [15:0] my);
    int x;
    int y;
    int ax;
    int ay;
    x  = mx;
    y  = my;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax == 0 && ay == 0) return DirStop;
    if (ay > 2 * ax) return (y > 0) ? DirFwd : DirBack;
    if (ax > 2 * ay) return (x > 0) ? DirRight : DirLeft;
    if (y > 0) return (x > 0) ? DirFwdRight : DirFwdLeft;
    return (x > 0) ? DirBackRight : DirBackLeft;
  endfunction

  function automatic void step_screen(input lss_in_t t, output lss_out_t r, output bit has_r);
    logic [31:0] gap;
    dir_e        d;
    r     = '0;
    has_r = 1'b0;
    if (!disp_on) return;
    case (scr_q)
      ScrConnecting: begin
        if (t.link_up) begin
          scr_q    = ScrConnected;
          since_q  = t.now_ms;
          redraw_q = 1'b1;
        end
      end
      ScrConnected: begin
        gap = t.now_ms - since_q;
        if (!t.link_up) begin
          scr_q    = ScrConnecting;
          redraw_q = 1'b1;
        end else if (gap >= hold_ms) begin
          scr_q    = ScrDirection;
          redraw_q = 1'b1;
        end
      end
      default: begin
        if (!t.link_up) begin
          scr_q    = ScrConnecting;
          redraw_q = 1'b1;
        end else begin
          d = sort_motion(t.motion_x, t.motion_y);
          if (d != dir_q) begin
            dir_q    = d;
            redraw_q = 1'b1;
          end
        end
      end
    endcase
    gap = t.now_ms - spun_q;
    if (scr_q == ScrConnecting && gap >= step_ms) begin
      spun_q   = t.now_ms;
      spin_q   = (spin_q + 1) % SpinnerPositions;
      redraw_q = 1'b1;
    end
    r.screen        = scr_q;
    r.direction     = dir_q;
    r.spinner_phase = 3'(spin_q);
    r.redraw        = redraw_q;
    r.flush_page    = page_q;
    redraw_q        = 1'b0;
    page_q          = page_q + PageStep;
    has_r           = 1'b1;
  endfunction

  function automatic void note_mismatch(string what, lss_out_t want, lss_out_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t %s: want scr=%0d dir=%0d spin=%0d redraw=%0b page=%0d",
               $time, what, want.screen, want.direction, want.spinner_phase,
               want.redraw, want.flush_page,
               " / got scr=%0d dir=%0d spin=%0d redraw=%0b page=%0d",
               got.screen, got.direction, got.spinner_phase, got.redraw, got.flush_page);
  endfunction

  // monitor: check results, predict accepted ticks, track register writes
  always @(posedge clk_i) begin
    lss_out_t want;
    lss_out_t nxt;
    bit       has;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (screens_due.size() == 0) begin
          note_mismatch("result with none due", '0, out_item_o);
        end else begin
          want = screens_due.pop_front();
          if (out_item_o.screen !== want.screen ||
              out_item_o.direction !== want.direction ||
              out_item_o.spinner_phase !== want.spinner_phase ||
              out_item_o.redraw !== want.redraw ||
              out_item_o.flush_page !== want.flush_page)
            note_mismatch("result mismatch", want, out_item_o);
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        step_screen(in_item_i, nxt, has);
        if (has) screens_due.push_back(nxt);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgHoldTime: hold_ms = cfg_data_i;
          CfgSpinStep: step_ms = cfg_data_i;
          CfgDisplay:  disp_on = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // driver: hold a stalled transaction, otherwise idle now and then
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (ticks_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_item_i  <= ticks_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  task automatic push_tick(input logic [31:0] now, input logic link,
                           input logic signed [15:0] mx, input logic signed [15:0] my);
    lss_in_t t;
    t.now_ms   = now;
    t.link_up  = link;
    t.motion_x = mx;
    t.motion_y = my;
    clock_ms   = now;
    link_st    = link;
    ticks_q.push_back(t);
  endtask

  task automatic pick_motion(output logic signed [15:0] mx, output logic signed [15:0] my);
    logic [15:0] corner[5];
    int          a;
    int          b;
    corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    case ($urandom_range(3))
      0: begin
        mx = 16'($urandom);
        my = 16'($urandom);
      end
      1: begin
        mx = 16'($urandom_range(16)) - 16'd8;
        my = 16'($urandom_range(16)) - 16'd8;
      end
      2: begin
        mx = corner[$urandom_range(4)];
        my = corner[$urandom_range(4)];
      end
      default: begin
        // around the 2:1 slope boundary
        a = $urandom_range(16383);
        b = 2 * a + $urandom_range(2) - 1;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
        if ($urandom_range(1)) begin
          mx = 16'(a);
          my = 16'(b);
        end else begin
          mx = 16'(b);
          my = 16'(a);
        end
      end
    endcase
  endtask

  task automatic queue_random_ticks(input int n);
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [31:0]        now;
    logic               link;
    now  = clock_ms;
    link = link_st;
    repeat (n) begin
      case ($urandom_range(9))
        0:       now = now + $urandom;
        1:       ;
        default: now = now + $urandom_range(400);
      endcase
      if ($urandom_range(99) < 8) link = !link;
      pick_motion(mx, my);
      push_tick(now, link, mx, my);
    end
  endtask

  // wait until the block is idle: nothing queued, in flight or due
  task automatic drain();
    do @(posedge clk_i);
    while (ticks_q.size() != 0 || in_valid_i || screens_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] hold, input logic [31:0] step, input int n);
    write_reg(CfgHoldTime, hold);
    write_reg(CfgSpinStep, step);
    queue_random_ticks(n);
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgHoldTime;
    cfg_data_i  = '0;
    calm        = 1'b0;
    in_taken    = 1'b0;
    mismatches  = 0;
    clock_ms    = '0;
    link_st     = 1'b0;
    hold_ms     = HoldTimeRst;
    step_ms     = SpinStepRst;
    disp_on     = 1'b1;
    scr_q       = ScrConnecting;
    dir_q       = DirStop;
    spin_q      = 0;
    page_q      = '0;
    redraw_q    = 1'b1;
    since_q     = '0;
    spun_q      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: spinner, connect, hold, every direction class
    push_tick(32'd0, 1'b0, 16'sd0, 16'sd0);
    push_tick(32'd100, 1'b0, 16'sd0, 16'sd0);
    push_tick(32'd150, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'd1149, 1'b1, 16'sd5, 16'sd5);
    push_tick(32'd1150, 1'b1, 16'sd5, 16'sd5);
    push_tick(32'd1151, 1'b1, 16'sd0, 16'sd32767);
    push_tick(32'd1152, 1'b1, 16'sd0, -16'sd32768);
    push_tick(32'd1153, 1'b1, -16'sd32768, 16'sd0);
    push_tick(32'd1154, 1'b1, 16'sd32767, 16'sd0);
    push_tick(32'd1155, 1'b1, -16'sd1, 16'sd1);
    push_tick(32'd1156, 1'b1, 16'sd1, 16'sd2);
    push_tick(32'd1157, 1'b1, 16'sd32767, -16'sd32768);
    push_tick(32'd1158, 1'b1, -16'sd32768, -16'sd32768);
    push_tick(32'd1159, 1'b1, -16'sd32768, 16'sd16384);
    push_tick(32'd1160, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'd1161, 1'b0, 16'sd3, 16'sd3);
    // hold time measured across the timestamp wrap
    push_tick(32'hFFFF_FF00, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'h0000_02E7, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'h0000_02E8, 1'b1, 16'sd3, -16'sd1);
    push_tick(32'h0000_02E9, 1'b1, 16'sd3, -16'sd1);
    drain();

    write_reg(CfgHoldTime, 32'd0);
    write_reg(CfgSpinStep, 32'd0);
    push_tick(32'h0000_02EA, 1'b0, 16'sd0, 16'sd0);
    push_tick(32'h0000_02EA, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'h0000_02EA, 1'b1, 16'sd0, 16'sd0);
    drain();

    write_reg(CfgHoldTime, 32'hFFFF_FFFF);
    write_reg(CfgSpinStep, 32'hFFFF_FFFF);
    write_reg(CfgUnused, 32'd0);
    push_tick(32'h0000_02EB, 1'b0, 16'sd0, 16'sd0);
    push_tick(32'h0000_02EB, 1'b1, 16'sd0, 16'sd0);
    push_tick(32'h0000_02EA, 1'b1, 16'sd7, 16'sd0);
    drain();

    // display absent: ticks are consumed without a result
    write_reg(CfgDisplay, 32'd0);
    push_tick(32'h0000_0300, 1'b0, 16'sd1, 16'sd1);
    push_tick(32'h0000_0400, 1'b1, 16'sd1, 16'sd1);
    drain();
    write_reg(CfgDisplay, 32'hFFFF_FFFF);

    run_phase(32'd1000, 32'd100, 250);
    run_phase(32'd0, 32'd0, 120);
    calm = 1'b1;
    run_phase(32'd37, 32'd13, 200);
    calm = 1'b0;
    run_phase($urandom_range(2000), $urandom_range(300), 250);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 80);
    write_reg(CfgDisplay, 32'd0);
    queue_random_ticks(40);
    drain();
    write_reg(CfgDisplay, 32'd1);
    run_phase($urandom_range(600), $urandom_range(150), 200);

    if (mismatches == 0 && screens_due.size() == 0) begin
      $display("link_status_screen_sequencer_tb OK");
    end else begin
      $display("link_status_screen_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule
